// ----- rtl/core/mhic_pkg.sv -----
// mhic_pkg: shared types and constants for the hard-iron calibrator
// used by the channel interfaces, the control unit, the axis lanes and the top level
`timescale 1ns / 1ps

package mhic_pkg;

  // axis sample and offset word
  typedef logic signed [15:0] axis_t;

  localparam int unsigned NUM_AXES = 3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_CAL_WINDOW    = 2'd1,
    CFG_OFFSET_EN     = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_addr_t;

  // register reset values
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd100000;
  localparam logic [30:0] CAL_WINDOW_RST    = 31'd30000000;
  localparam logic        OFFSET_EN_RST     = 1'b1;

  // per-beat control broadcast to the axis lanes
  typedef struct packed {
    logic acc;     // beat taken and due
    logic start;   // calibration starts on this beat
    logic track;   // window open: widen min and max
    logic close;   // window closed: compute offsets
    logic ofs_en;  // subtract stored offsets
  } lane_ctl_t;

  // status from the control unit to the output stage
  typedef struct packed {
    logic calibrating;
    logic done;
  } ctl_stat_t;

endpackage

// ----- rtl/core/mhic_in_if.sv -----
// mhic_in_if: input sample channel (valid/ready plus timestamped sample)
// depends on mhic_pkg for the axis type
`timescale 1ns / 1ps

interface mhic_in_if import mhic_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  axis_t       mag_x;
  axis_t       mag_y;
  axis_t       mag_z;
  logic        start_cal;

  modport source (output valid, now_us, mag_x, mag_y, mag_z, start_cal, input ready);
  modport sink (input valid, now_us, mag_x, mag_y, mag_z, start_cal, output ready);
endinterface

// ----- rtl/core/mhic_out_if.sv -----
// mhic_out_if: result channel (valid/ready plus corrected sample and offsets)
// depends on mhic_pkg for the axis type
`timescale 1ns / 1ps

interface mhic_out_if import mhic_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  accepted;
  axis_t out_x;
  axis_t out_y;
  axis_t out_z;
  logic  calibrating;
  logic  cal_done;
  axis_t offset_x;
  axis_t offset_y;
  axis_t offset_z;

  modport source (output valid, accepted, out_x, out_y, out_z, calibrating, cal_done,
                  offset_x, offset_y, offset_z, input ready);
  modport sink (input valid, accepted, out_x, out_y, out_z, calibrating, cal_done,
                offset_x, offset_y, offset_z, output ready);
endinterface

// ----- rtl/core/mhic_cfg_if.sv -----
// mhic_cfg_if: configuration write channel (valid/ready, register index, data)
// depends on mhic_pkg for the register index type
`timescale 1ns / 1ps

interface mhic_cfg_if import mhic_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_addr_t   addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/mag_hard_iron_calibrator.sv -----
// mag_hard_iron_calibrator: rate-limited hard-iron min/max calibration, three axis lanes
// each accepted input beat is registered and appears as its result beat in the next cycle
// throughput: one beat per cycle while out_bus.ready is high or the output register is empty
// the output register takes a new result in the cycle its previous one is taken
// reset (rst_n, synchronous): registers to defaults, due time, window and offsets cleared
// depends on mhic_pkg, mhic_in_if, mhic_out_if, mhic_cfg_if, mhic_ctrl, mhic_lane
`timescale 1ns / 1ps

module mag_hard_iron_calibrator import mhic_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mhic_in_if.sink    in_bus,
  mhic_out_if.source out_bus,
  mhic_cfg_if.sink   cfg_bus
);

  lane_ctl_t ctl;
  ctl_stat_t stat;
  logic      take;
  axis_t     raw    [NUM_AXES];
  axis_t     corr   [NUM_AXES];
  axis_t     ofs    [NUM_AXES];

  logic  out_valid_r, out_valid_nxt;
  logic  acc_r;
  axis_t corr_r [NUM_AXES];
  axis_t ofs_r  [NUM_AXES];
  logic  cal_r;
  logic  done_r;

  // handshakes
  assign in_bus.ready  = ~out_valid_r | out_bus.ready;
  assign take          = in_bus.valid & in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  mhic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_bus.valid),
    .cfg_addr  (cfg_bus.addr),
    .cfg_data  (cfg_bus.data),
    .take      (take),
    .now_us    (in_bus.now_us),
    .start_cal (in_bus.start_cal),
    .ctl       (ctl),
    .stat      (stat)
  );

  assign raw[0] = in_bus.mag_x;
  assign raw[1] = in_bus.mag_y;
  assign raw[2] = in_bus.mag_z;

  // axis lanes
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mhic_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .raw        (raw[a]),
      .corr       (corr[a]),
      .offset_new (ofs[a])
    );
  end

  // merge lanes and status into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) out_valid_nxt = 1'b1;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r  <= ctl.acc;
      cal_r  <= stat.calibrating;
      done_r <= stat.done;
      for (int i = 0; i < NUM_AXES; i++) begin
        corr_r[i] <= ctl.acc ? corr[i] : '0;
        ofs_r[i]  <= ofs[i];
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.accepted    = acc_r;
  assign out_bus.out_x       = corr_r[0];
  assign out_bus.out_y       = corr_r[1];
  assign out_bus.out_z       = corr_r[2];
  assign out_bus.calibrating = cal_r;
  assign out_bus.cal_done    = done_r;
  assign out_bus.offset_x    = ofs_r[0];
  assign out_bus.offset_y    = ofs_r[1];
  assign out_bus.offset_z    = ofs_r[2];

endmodule

// ----- rtl/core/mhic_ctrl.sv -----
// mhic_ctrl: configuration registers, rate limiter and calibration window tracking
// depends on mhic_pkg; drives the lane control struct and the status struct
`timescale 1ns / 1ps

module mhic_ctrl import mhic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_addr_t   cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        take,
  input  logic [31:0] now_us,
  input  logic        start_cal,
  output lane_ctl_t   ctl,
  output ctl_stat_t   stat
);

  logic [31:0] period_r, period_nxt;
  logic [30:0] window_r, window_nxt;
  logic        ofs_en_r, ofs_en_nxt;
  logic [31:0] next_due_r, next_due_nxt;
  logic        active_r, active_nxt;
  logic [31:0] cal_start_r, cal_start_nxt;

  logic [31:0] late;
  logic        due;
  logic        acc;
  logic        start;
  logic [31:0] due_new;
  logic [31:0] cal_start_eff;
  logic [31:0] elapsed;
  logic        in_window;
  logic        active_eff;

  // configuration register writes
  always_comb begin
    period_nxt = period_r;
    window_nxt = window_r;
    ofs_en_nxt = ofs_en_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SAMPLE_PERIOD: period_nxt = cfg_data;
        CFG_CAL_WINDOW:    window_nxt = cfg_data[30:0];
        CFG_OFFSET_EN:     ofs_en_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // rate limit: signed wrap compare against next due time
  assign late    = now_us - next_due_r;
  assign due     = ~late[31];
  assign acc     = take & due;
  assign start   = acc & start_cal;
  assign due_new = now_us + period_r;

  // window test on the updated due time
  assign cal_start_eff = start ? due_new : cal_start_r;
  assign elapsed       = due_new - cal_start_eff;
  assign in_window     = elapsed < {1'b0, window_r};
  assign active_eff    = start | active_r;

  assign ctl.acc    = acc;
  assign ctl.start  = start;
  assign ctl.track  = acc & active_eff & in_window;
  assign ctl.close  = acc & active_eff & ~in_window;
  assign ctl.ofs_en = ofs_en_r;

  // state update on an accepted sample
  always_comb begin
    next_due_nxt  = next_due_r;
    active_nxt    = active_r;
    cal_start_nxt = cal_start_r;
    if (acc) begin
      next_due_nxt  = due_new;
      active_nxt    = active_eff & in_window;
      cal_start_nxt = cal_start_eff;
    end
  end

  assign stat.calibrating = acc ? (active_eff & in_window) : active_r;
  assign stat.done        = ctl.close;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= SAMPLE_PERIOD_RST;
      window_r    <= CAL_WINDOW_RST;
      ofs_en_r    <= OFFSET_EN_RST;
      next_due_r  <= '0;
      active_r    <= 1'b0;
      cal_start_r <= '0;
    end else begin
      period_r    <= period_nxt;
      window_r    <= window_nxt;
      ofs_en_r    <= ofs_en_nxt;
      next_due_r  <= next_due_nxt;
      active_r    <= active_nxt;
      cal_start_r <= cal_start_nxt;
    end
  end

endmodule

// ----- rtl/core/mhic_lane.sv -----
// mhic_lane: one axis lane - offset subtraction, min/max tracking, offset update
// depends on mhic_pkg for the axis type and the lane control struct
`timescale 1ns / 1ps

module mhic_lane import mhic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  input  axis_t     raw,
  output axis_t     corr,
  output axis_t     offset_new
);

  axis_t       min_r, min_nxt;
  axis_t       max_r, max_nxt;
  axis_t       ofs_r, ofs_nxt;
  axis_t       ofs_eff;
  axis_t       min_eff;
  axis_t       max_eff;
  logic [16:0] sum;
  logic [16:0] sum_adj;

  // offsets are cleared by a calibration start before correction
  assign ofs_eff = ctl.start ? '0 : ofs_r;
  assign corr    = ctl.ofs_en ? axis_t'(raw - ofs_eff) : raw;

  // seed on start, otherwise current extremes
  assign min_eff = ctl.start ? raw : min_r;
  assign max_eff = ctl.start ? raw : max_r;

  // min/max tracking
  always_comb begin
    min_nxt = min_eff;
    max_nxt = max_eff;
    if (ctl.track) begin
      if (corr < min_eff) min_nxt = corr;
      if (corr > max_eff) max_nxt = corr;
    end
  end

  // midpoint, truncated toward zero
  assign sum     = {min_eff[15], min_eff} + {max_eff[15], max_eff};
  assign sum_adj = sum + {16'd0, sum[16]};

  always_comb begin
    ofs_nxt = ofs_eff;
    if (ctl.close) ofs_nxt = sum_adj[16:1];
    if (!ctl.acc) ofs_nxt = ofs_r;
  end

  assign offset_new = ofs_nxt;

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= '0;
    end else begin
      ofs_r <= ofs_nxt;
    end
  end

endmodule
